// ===== rtl/http_tok_pkg.sv =====
// Shared types and constants for the HTTP request tokenizer.
`default_nettype none
package http_tok_pkg;

  // Request separator bytes
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharColon = 8'h3A;

  // Status codes
  localparam logic [1:0] StatusParsing = 2'd0;
  localparam logic [1:0] StatusSuccess = 2'd1;
  localparam logic [1:0] StatusFailure = 2'd2;

  // Field kind codes
  localparam logic [2:0] KindMethod = 3'd0;
  localparam logic [2:0] KindRoute  = 3'd1;
  localparam logic [2:0] KindProto  = 3'd2;
  localparam logic [2:0] KindHname  = 3'd3;
  localparam logic [2:0] KindHvalue = 3'd4;

  // Parse phase, one-hot
  typedef enum logic [6:0] {
    PhMethod  = 7'b000_0001,
    PhRoute   = 7'b000_0010,
    PhProto   = 7'b000_0100,
    PhHname   = 7'b000_1000,
    PhHvalue  = 7'b001_0000,
    PhSuccess = 7'b010_0000,
    PhFail    = 7'b100_0000
  } phase_e;

  // Tokenizer state carried from item to item
  typedef struct packed {
    phase_e phase;
    logic   prev_was_cr;
    logic   hname_nonempty;
    logic   hvalue_started;
  } tok_state_t;

  // One result item
  typedef struct packed {
    logic [1:0] status;
    logic       char_valid;
    logic [2:0] field_kind;
    logic [7:0] char_out;
    logic       field_done;
  } tok_result_t;

endpackage
`default_nettype wire

// ===== rtl/http_tok_step.sv =====
// Per-byte decision logic: next tokenizer state and the result for one item.
`default_nettype none
module http_tok_step (
  input  http_tok_pkg::tok_state_t  state_i,
  input  logic                      action_i,
  input  logic [7:0]                data_byte_i,
  output http_tok_pkg::tok_state_t  state_o,
  output http_tok_pkg::tok_result_t result_o
);

  logic       is_cr;
  logic       term;
  logic       keep;
  logic       done;
  logic [2:0] kind;

  assign is_cr = (data_byte_i == http_tok_pkg::CharCr);
  assign term  = (data_byte_i == http_tok_pkg::CharLf) && state_i.prev_was_cr;

  // Decide the field walk for one pushed byte
  always_comb begin
    state_o = state_i;
    keep    = 1'b0;
    done    = 1'b0;
    if (action_i) begin
      state_o.phase = http_tok_pkg::PhFail;
    end else begin
      state_o.prev_was_cr = is_cr;
      if (!is_cr) begin
        unique case (state_i.phase)
          http_tok_pkg::PhMethod, http_tok_pkg::PhRoute: begin
            if (term) begin
              state_o.phase = http_tok_pkg::PhFail;
            end else if (data_byte_i == http_tok_pkg::CharSpace) begin
              state_o.phase = (state_i.phase == http_tok_pkg::PhMethod) ?
                              http_tok_pkg::PhRoute : http_tok_pkg::PhProto;
              done = 1'b1;
            end else begin
              keep = 1'b1;
            end
          end
          http_tok_pkg::PhProto: begin
            if (term) begin
              state_o.phase          = http_tok_pkg::PhHname;
              state_o.hname_nonempty = 1'b0;
              done                   = 1'b1;
            end else begin
              keep = 1'b1;
            end
          end
          http_tok_pkg::PhHname: begin
            if (term) begin
              state_o.phase = state_i.hname_nonempty ?
                              http_tok_pkg::PhFail : http_tok_pkg::PhSuccess;
            end else if (data_byte_i == http_tok_pkg::CharColon) begin
              state_o.phase          = http_tok_pkg::PhHvalue;
              state_o.hvalue_started = 1'b0;
              done                   = 1'b1;
            end else begin
              keep                   = 1'b1;
              state_o.hname_nonempty = 1'b1;
            end
          end
          http_tok_pkg::PhHvalue: begin
            if (term) begin
              state_o.phase          = http_tok_pkg::PhHname;
              state_o.hname_nonempty = 1'b0;
              done                   = 1'b1;
            end else if (data_byte_i != http_tok_pkg::CharSpace ||
                         state_i.hvalue_started) begin
              keep                   = 1'b1;
              state_o.hvalue_started = 1'b1;
            end
          end
          default: begin
            // finished request: only the CR tracking moves
          end
        endcase
      end
    end
  end

  // Encode the field being parsed before this byte
  always_comb begin
    unique case (state_i.phase)
      http_tok_pkg::PhMethod: kind = http_tok_pkg::KindMethod;
      http_tok_pkg::PhRoute:  kind = http_tok_pkg::KindRoute;
      http_tok_pkg::PhProto:  kind = http_tok_pkg::KindProto;
      http_tok_pkg::PhHname:  kind = http_tok_pkg::KindHname;
      http_tok_pkg::PhHvalue: kind = http_tok_pkg::KindHvalue;
      default:                kind = http_tok_pkg::KindMethod;
    endcase
  end

  // Build the result; an abort zeroes everything but the status
  always_comb begin
    unique case (state_o.phase)
      http_tok_pkg::PhSuccess: result_o.status = http_tok_pkg::StatusSuccess;
      http_tok_pkg::PhFail:    result_o.status = http_tok_pkg::StatusFailure;
      default:                 result_o.status = http_tok_pkg::StatusParsing;
    endcase
    result_o.char_valid = keep;
    result_o.field_kind = action_i ? http_tok_pkg::KindMethod : kind;
    result_o.char_out   = keep ? data_byte_i : 8'h00;
    result_o.field_done = done;
  end

endmodule
`default_nettype wire

// ===== rtl/http_request_tokenizer_core.sv =====
// Top level of the HTTP request tokenizer: input register, decision logic, result register.
`default_nettype none
// Streams an HTTP request head one byte per transfer and tags each byte with
// its field (method, route, protocol, header name, header value), whether it
// closed that field, and the running status (parsing, success, failure).
// One item is taken every cycle while the input side does not stall; a transfer
// is decided while it sits in the input register and its result is loaded
// into the result register once that register can take it. The tokenizer
// state advances as an item moves from the input register to the result
// register, and the input side stalls only while the result register is
// full and stalled.
module http_request_tokenizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic       char_valid_o,
  output logic [2:0] field_kind_o,
  output logic [7:0] char_out_o,
  output logic       field_done_o
);

  logic                      in_valid_q;
  logic                      action_q;
  logic [7:0]                data_byte_q;
  logic                      out_valid_q;
  http_tok_pkg::tok_result_t result_q;
  http_tok_pkg::tok_result_t result_d;
  http_tok_pkg::tok_state_t  state_q;
  http_tok_pkg::tok_state_t  state_d;
  logic                      out_ready;
  logic                      advance;
  logic                      in_xfer;

  // Handshake control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  http_tok_step u_step (
    .state_i     (state_q),
    .action_i    (action_q),
    .data_byte_i (data_byte_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  // Hold input item until it is decided
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q    <= action_i;
      data_byte_q <= data_byte_i;
    end
  end

  // Advance tokenizer state once per decided item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= http_tok_pkg::PhMethod;
      state_q.prev_was_cr    <= 1'b0;
      state_q.hname_nonempty <= 1'b0;
      state_q.hvalue_started <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = result_q.status;
  assign char_valid_o = result_q.char_valid;
  assign field_kind_o = result_q.field_kind;
  assign char_out_o   = result_q.char_out;
  assign field_done_o = result_q.field_done;

endmodule
`default_nettype wire
